// ----- src/sahc_pkg.sv -----
// Shared constants and controller/datapath interface types for the cache hit check.
`timescale 1ns / 1ps
`default_nettype none

package sahc_pkg;

   localparam int BLOCK_BYTES_DEF = 64;
   localparam int CACHE_BYTES_DEF = 262144;
   localparam int WAYS_DEF        = 8;
   localparam int ADDR_BITS_DEF   = 32;

   // Stream payload widths: a 32-bit address in, one hit flag padded to a byte out.
   localparam int REQ_TDATA_BITS = 32;
   localparam int RSP_TDATA_BITS = 8;

   typedef struct packed {
      logic clear_step;   // zero one set row of the tag store
      logic lookup;       // capture the address and read its set row
      logic update;       // resolve hit/miss, refill on miss, load the result
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;   // the clear sweep is at its last row
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- src/sahc_ctrl.sv -----
// Controller state machine: clearing sweep, address lookup and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module sahc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire sahc_pkg::ctrl_status_type status,
   output sahc_pkg::ctrl_cmd_type        cmd
);

   localparam logic [1:0] ST_CLEAR   = 2'd0;
   localparam logic [1:0] ST_IDLE    = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign cmd.clear_step = (state_ff == ST_CLEAR);
   assign cmd.lookup     = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.update     = (state_ff == ST_COMPARE) && out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/sahc_datapath.sv -----
// Datapath: set row memory, tag compare across ways, victim choice and refill.
`timescale 1ns / 1ps
`default_nettype none

module sahc_datapath #(
   parameter int BLOCK_BYTES = sahc_pkg::BLOCK_BYTES_DEF,
   parameter int CACHE_BYTES = sahc_pkg::CACHE_BYTES_DEF,
   parameter int WAYS        = sahc_pkg::WAYS_DEF,
   parameter int ADDR_BITS   = sahc_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [sahc_pkg::REQ_TDATA_BITS-1:0] address,
   input  wire sahc_pkg::ctrl_cmd_type              cmd,
   output sahc_pkg::ctrl_status_type                status,
   output logic                                     hit
);

   localparam int AW          = sahc_pkg::REQ_TDATA_BITS;
   localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
   localparam int SETS_RAW    = CACHE_BYTES / (BLOCK_BYTES * WAYS);
   localparam int NUM_SETS    = (SETS_RAW > 0) ? SETS_RAW : 1;
   localparam int SET_SHIFT   = $clog2(NUM_SETS);
   localparam int SET_BITS    = (NUM_SETS > 1) ? SET_SHIFT : 1;
   localparam int USED_BITS   = (ADDR_BITS < AW) ? ADDR_BITS : AW;
   localparam int TAG_RAW     = USED_BITS - OFFSET_BITS - SET_SHIFT;
   localparam int TAG_BITS    = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LEVELS      = $clog2(WAYS);
   localparam int LEAVES      = 1 << LEVELS;
   localparam int ROW_BITS    = WAYS * (TAG_BITS + 1);
   localparam logic [AW-1:0] ADDR_MASK =
      (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(NUM_SETS - 1);

   // One row per set: valid bits in the low WAYS bits, then one tag per way.
   logic [ROW_BITS-1:0] row_mem [NUM_SETS];

   logic [ROW_BITS-1:0] rd_row_ff;
   logic [SET_BITS-1:0] set_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [SET_BITS-1:0] clr_idx_ff;
   logic                hit_ff;

   logic [AW-1:0]       addr_used;
   logic [AW-1:0]       addr_block;
   logic [AW-1:0]       addr_tag;
   logic [SET_BITS-1:0] req_set;
   logic [TAG_BITS-1:0] req_tag;

   logic                way_valid [LEAVES];
   logic [TAG_BITS-1:0] way_tag   [LEAVES];
   logic                lookup_hit;
   logic [WAY_BITS-1:0] first_way;
   logic [WAY_BITS-1:0] victim;
   logic [ROW_BITS-1:0] new_row;

   logic                node_en  [LEVELS+1][LEAVES];
   logic [TAG_BITS-1:0] node_tag [LEVELS+1][LEAVES];
   logic [WAY_BITS-1:0] node_idx [LEVELS+1][LEAVES];

   logic                wr_en;
   logic [SET_BITS-1:0] wr_idx;
   logic [ROW_BITS-1:0] wr_row;

   // Sizes are powers of two, so set and tag are plain bit fields of the address.
   assign addr_used  = address & ADDR_MASK;
   assign addr_block = addr_used >> OFFSET_BITS;
   assign addr_tag   = addr_used >> (OFFSET_BITS + SET_SHIFT);
   assign req_set    = (NUM_SETS > 1) ? addr_block[SET_BITS-1:0] : '0;
   assign req_tag    = addr_tag[TAG_BITS-1:0];

   always_comb begin
      for (int w = 0; w < LEAVES; w++) begin
         if (w < WAYS) begin
            way_valid[w] = rd_row_ff[w];
            way_tag[w]   = rd_row_ff[WAYS + w*TAG_BITS +: TAG_BITS];
         end else begin
            way_valid[w] = 1'b0;
            way_tag[w]   = '0;
         end
      end
   end

   always_comb begin
      lookup_hit = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (way_valid[w] && (way_tag[w] == tag_ff)) begin
            lookup_hit = 1'b1;
         end
      end
   end

   // The scan restarts at the last empty or zero-tag way; past that point it
   // keeps the leftmost smallest tag, which the tree below finds in log steps.
   always_comb begin
      first_way = '0;
      for (int w = 1; w < WAYS; w++) begin
         if (!way_valid[w] || (way_tag[w] == '0)) begin
            first_way = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      logic pick_left;
      pick_left = 1'b0;
      for (int l = 0; l <= LEVELS; l++) begin
         for (int j = 0; j < LEAVES; j++) begin
            node_en[l][j]  = 1'b0;
            node_tag[l][j] = '0;
            node_idx[l][j] = '0;
         end
      end
      for (int j = 0; j < LEAVES; j++) begin
         node_en[0][j]  = (j < WAYS) && (WAY_BITS'(j) >= first_way);
         node_tag[0][j] = way_tag[j];
         node_idx[0][j] = WAY_BITS'(j);
      end
      for (int l = 0; l < LEVELS; l++) begin
         for (int j = 0; j < (LEAVES >> (l + 1)); j++) begin
            pick_left = !node_en[l][2*j+1] ||
                        (node_en[l][2*j] && (node_tag[l][2*j] <= node_tag[l][2*j+1]));
            node_en[l+1][j]  = node_en[l][2*j] || node_en[l][2*j+1];
            node_tag[l+1][j] = pick_left ? node_tag[l][2*j] : node_tag[l][2*j+1];
            node_idx[l+1][j] = pick_left ? node_idx[l][2*j] : node_idx[l][2*j+1];
         end
      end
   end

   assign victim = node_idx[LEVELS][0];

   always_comb begin
      new_row = rd_row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_BITS'(w) == victim) begin
            new_row[w]                              = 1'b1;
            new_row[WAYS + w*TAG_BITS +: TAG_BITS]  = tag_ff;
         end
      end
   end

   assign wr_en  = cmd.clear_step || (cmd.update && !lookup_hit);
   assign wr_idx = cmd.clear_step ? clr_idx_ff : set_ff;
   assign wr_row = cmd.clear_step ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_idx] <= wr_row;
      end
      if (cmd.lookup) begin
         rd_row_ff <= row_mem[req_set];
         set_ff    <= req_set;
         tag_ff    <= req_tag;
      end
      if (cmd.update) begin
         hit_ff <= lookup_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   assign status.clear_last = (clr_idx_ff == LAST_SET);
   assign hit               = hit_ff;

endmodule

`default_nettype wire

// ----- src/set_assoc_cache_hit_check.sv -----
// Top level of the set-associative cache hit check with refill on miss.
//
// The req channel carries one byte address per item; the rsp channel returns
// one item per address whose bit 0 is 1 on a hit and 0 on a miss. A miss
// writes the tag into a victim way of the set before the next item is taken.
// An item accepted at one clock edge has its set row read at that edge; in
// the compare state, once the result register is free, the compare is
// resolved, a miss is refilled and the result register is loaded, which
// raises rsp_tvalid. The block takes a new item only after the last one has
// been resolved, since the set row is read and then written in the single
// tag memory. While rsp_tready is low, one finished result waits in the output
// register and the next item is still accepted and looked up; its update
// holds until the waiting result is taken. After reset the tag memory is swept
// to zero, one set row per cycle, over every set (512 at the default sizes);
// req_tready stays low until the sweep ends. Sizes are expected to be powers of two.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_hit_check #(
   parameter int BLOCK_BYTES = sahc_pkg::BLOCK_BYTES_DEF,
   parameter int CACHE_BYTES = sahc_pkg::CACHE_BYTES_DEF,
   parameter int WAYS        = sahc_pkg::WAYS_DEF,
   parameter int ADDR_BITS   = sahc_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [sahc_pkg::REQ_TDATA_BITS-1:0] req_tdata,   // [31:0] address
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [sahc_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata    // [0] hit, [7:1] zero
);

   sahc_pkg::ctrl_cmd_type    cmd;
   sahc_pkg::ctrl_status_type status;
   logic                      hit;

   sahc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sahc_datapath #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .CACHE_BYTES (CACHE_BYTES),
      .WAYS        (WAYS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .address (req_tdata),
      .cmd     (cmd),
      .status  (status),
      .hit     (hit)
   );

   assign rsp_tdata = {{(sahc_pkg::RSP_TDATA_BITS-1){1'b0}}, hit};

   // Only one item is in the lookup at a time.
   assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> !req_tready)
      else $error("item accepted while a lookup is in progress");

   // A resolved lookup always shows up as a valid result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_tvalid)
      else $error("resolved lookup did not produce a result");

   // The clearing sweep never overlaps a lookup or an update.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> (!req_tready && !cmd.update))
      else $error("item handled during the clearing sweep");

   // Lookup and update use the memory in different cycles.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.lookup && cmd.update))
      else $error("lookup and update issued together");

endmodule

`default_nettype wire

// ----- verif/set_assoc_cache_hit_check_checker.sv -----
// Checker for the cache hit check: mirrors the tag store and compares every returned hit flag.
`timescale 1ns / 1ps

module set_assoc_cache_hit_check_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [sahc_pkg::REQ_TDATA_BITS-1:0] req_tdata,   // [31:0] address
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [sahc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,   // [0] hit, [7:1] zero
   output int                                  fail_count,
   output int                                  outstanding
);

   localparam int NUM_WAYS    = sahc_pkg::WAYS_DEF;
   localparam int SETS_RAW    = sahc_pkg::CACHE_BYTES_DEF / (sahc_pkg::BLOCK_BYTES_DEF * NUM_WAYS);
   localparam int NUM_SETS    = (SETS_RAW > 0) ? SETS_RAW : 1;
   localparam int OFFSET_BITS = $clog2(sahc_pkg::BLOCK_BYTES_DEF);
   localparam int SET_BITS    = $clog2(NUM_SETS);
   localparam int TAG_BITS    = sahc_pkg::ADDR_BITS_DEF - OFFSET_BITS - SET_BITS;

   logic                way_valid [NUM_SETS][NUM_WAYS];
   logic [TAG_BITS-1:0] way_tag   [NUM_SETS][NUM_WAYS];
   logic                hit_expected_q [$];

   // Looks the address up in the mirrored tag store and refills a victim way on a miss.
   function automatic logic lookup_and_fill(input logic [31:0] address);
      int                  set_index;
      int                  victim;
      logic [TAG_BITS-1:0] tag_value;
      set_index = (address >> OFFSET_BITS) % NUM_SETS;
      tag_value = TAG_BITS'(address >> (OFFSET_BITS + SET_BITS));
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (way_valid[set_index][w] && way_tag[set_index][w] == tag_value) return 1'b1;
      end
      // The victim's stored tag is compared even when that way is invalid.
      victim = 0;
      for (int w = 1; w < NUM_WAYS; w++) begin
         if (!way_valid[set_index][w] || way_tag[set_index][w] == '0 ||
             way_tag[set_index][w] < way_tag[set_index][victim]) begin
            victim = w;
         end
      end
      way_valid[set_index][victim] = 1'b1;
      way_tag[set_index][victim]   = tag_value;
      return 1'b0;
   endfunction

   always @(posedge clock) begin : watch_channels
      logic expected_hit;
      if (reset) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               way_valid[s][w] = 1'b0;
               way_tag[s][w]   = '0;
            end
         end
         hit_expected_q.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         // A result taken at this edge always belongs to an earlier item.
         if (rsp_tvalid && rsp_tready) begin
            if (hit_expected_q.size() == 0) begin
               $error("unexpected result item: hit actual %0b", rsp_tdata[0]);
               fail_count <= fail_count + 1;
            end else begin
               expected_hit = hit_expected_q.pop_front();
               if (rsp_tdata[0] !== expected_hit) begin
                  $error("hit mismatch: expected %0b actual %0b", expected_hit, rsp_tdata[0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) hit_expected_q.push_back(lookup_and_fill(req_tdata));
         outstanding <= hit_expected_q.size();
      end
   end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the cache hit check: clock, reset, address stimulus and the verdict.
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_ITEMS  = 750;
   localparam int STEADY_ITEMS  = 80;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 4000;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [sahc_pkg::REQ_TDATA_BITS-1:0] req_tdata;     // [31:0] address
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [sahc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;     // [0] hit, [7:1] zero
   int                                  fail_count;
   int                                  outstanding;
   int                                  idle_cycles;
   int                                  hold_requests;
   bit                                  steady;
   logic [31:0]                         recent_addresses [$];

   set_assoc_cache_hit_check i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   set_assoc_cache_hit_check_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Address layout at the default sizes: tag [31:15], set [14:6], byte offset [5:0].
   function automatic logic [31:0] make_address(input logic [16:0] tag_value,
                                                input logic [8:0] set_index,
                                                input logic [5:0] offset);
      return {tag_value, set_index, offset};
   endfunction

   // Mostly a few busy sets with a small tag pool, so hits, refills and evictions all occur.
   function automatic logic [31:0] pick_address();
      int          mode;
      int          set_pick;
      int          tag_pick;
      logic [31:0] address;
      mode = $urandom_range(0, 9);
      if (mode < 3 && recent_addresses.size() > 0) begin
         address = recent_addresses[$urandom_range(0, recent_addresses.size() - 1)];
         address[5:0] = 6'($urandom_range(0, 63));
      end else if (mode < 7) begin
         set_pick = $urandom_range(0, 4);
         tag_pick = $urandom_range(0, 11);
         address = make_address((tag_pick == 11) ? 17'h1FFFF : tag_pick[16:0],
                                (set_pick == 4) ? 9'h1FF : set_pick[8:0],
                                6'($urandom_range(0, 63)));
      end else begin
         address = $urandom;
      end
      return address;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic send_address(input logic [31:0] address);
      req_tvalid <= 1'b1;
      req_tdata  <= address;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      recent_addresses.push_back(address);
      if (recent_addresses.size() > 24) void'(recent_addresses.pop_front());
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Result side: random stall bursts, one long hold on request, none near the end.
   initial begin : result_sink
      int holds_served;
      int burst;
      holds_served = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = holds_served + 1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [16:0] fill_tags [14];
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      hold_requests = 0;
      steady        = 1'b0;
      fill_tags = '{17'd7, 17'd3, 17'd9, 17'd0, 17'd4, 17'd6, 17'd8, 17'd2,
                    17'd10, 17'd0, 17'd2, 17'd7, 17'd10, 17'd5};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extremes of the address, both ends of the set range and a tag of zero.
      send_address(32'h0000_0000);
      send_address(32'h0000_003F);
      send_address(32'hFFFF_FFFF);
      send_address(32'hFFFF_FFC0);
      send_address(32'h0000_7FC0);
      send_address(32'hFFFF_8000);
      send_address(32'h0000_0000);
      // Fill one set past its ways, with a valid zero tag in it, then revisit evicted tags.
      foreach (fill_tags[i]) send_address(make_address(fill_tags[i], 9'd1, i[5:0]));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 200) hold_requests <= hold_requests + 1;
         if (n == 400) begin
            req_tvalid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         if (n == RANDOM_ITEMS - STEADY_ITEMS) steady = 1'b1;
         if (!steady && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 14));
         send_address(pick_address());
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
